### src/nmea_rmc_position_extractor_defines.svh
// ---------------------------------------------------------------------------
// NMEA RMC position extractor - assertion macros
// Concurrent assertion wrappers on clk / rst_n; compiled out by NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef NMEA_RMC_POSITION_EXTRACTOR_DEFINES_SVH
`define NMEA_RMC_POSITION_EXTRACTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// name: label, prop: property expression
`define NRPE_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("nrpe assertion failed");

// cond in this cycle implies nxt in the following cycle
`define NRPE_ASSERT_NEXT(name, cond, nxt) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error("nrpe assertion failed");

`else

`define NRPE_ASSERT(name, prop)
`define NRPE_ASSERT_NEXT(name, cond, nxt)

`endif

`endif

### src/nrpe_pkg.sv
// ---------------------------------------------------------------------------
// nrpe_pkg
// Shared types, codes and constants of the NMEA RMC position extractor.
// ---------------------------------------------------------------------------
package nrpe_pkg;

  localparam int FIELD_CHARS_DEF = 16;

  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 2;
  localparam int IDX_W       = 4;
  localparam int HDR_W       = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int OUT_TDATA_W = 16;

  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
  localparam logic [BYTE_W-1:0] CH_N      = 8'h4E;
  localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
  localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
  localparam logic [BYTE_W-1:0] CH_C      = 8'h43;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;

  localparam logic [HDR_W-1:0] HDR_IDLE  = 3'd0;
  localparam logic [HDR_W-1:0] HDR_START = 3'd1;
  localparam logic [HDR_W-1:0] HDR_DONE  = 3'd6;

  localparam logic [IDX_W-1:0] COMMA_MAX   = 4'd15;
  localparam logic [IDX_W-1:0] LAT_IDX_RST = 4'd3;
  localparam logic [IDX_W-1:0] LON_IDX_RST = 4'd5;

  localparam logic [CFG_INDEX_W-1:0] CFG_LAT_IDX = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LON_IDX = 2'd1;

  localparam logic [KIND_W-1:0] KIND_LAT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LON = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAT_RD,
    ST_LAT_LD,
    ST_LON_RD,
    ST_LON_LD,
    ST_END
  } nrpe_state_t;

  typedef struct packed {
    logic take;
    logic clr_idx;
    logic rd;
    logic load_lat;
    logic load_lon;
    logic load_end;
  } nrpe_cmd_t;

  typedef struct packed {
    logic end_hit;
    logic lat_more;
    logic lon_more;
    logic out_free;
  } nrpe_sts_t;

  // expected header byte at match position pos
  function automatic logic [BYTE_W-1:0] hdr_char(input logic [HDR_W-1:0] pos);
    logic [BYTE_W-1:0] c;
    case (pos)
      3'd1:    c = CH_G;
      3'd2:    c = CH_N;
      3'd3:    c = CH_R;
      3'd4:    c = CH_M;
      3'd5:    c = CH_C;
      default: c = CH_DOLLAR;
    endcase
    return c;
  endfunction

endpackage

### src/nrpe_ram.sv
// ---------------------------------------------------------------------------
// nrpe_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module nrpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### src/nrpe_ctrl.sv
// ---------------------------------------------------------------------------
// nrpe_ctrl
// Controller: takes bytes while idle, sequences the field read-out at the
// end of a sentence.
// ---------------------------------------------------------------------------
`include "nmea_rmc_position_extractor_defines.svh"

module nrpe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  nrpe_pkg::nrpe_sts_t sts,
  output nrpe_pkg::nrpe_cmd_t cmd
);
  import nrpe_pkg::*;

  nrpe_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
        if (in_tvalid && sts.end_hit) begin
          cmd.clr_idx = 1'b1;
          state_nxt   = ST_LAT_RD;
        end
      end
      ST_LAT_RD: begin
        if (sts.lat_more) begin
          cmd.rd    = 1'b1;
          state_nxt = ST_LAT_LD;
        end else begin
          cmd.clr_idx = 1'b1;
          state_nxt   = ST_LON_RD;
        end
      end
      ST_LAT_LD: begin
        if (sts.out_free) begin
          cmd.load_lat = 1'b1;
          state_nxt    = ST_LAT_RD;
        end
      end
      ST_LON_RD: begin
        if (sts.lon_more) begin
          cmd.rd    = 1'b1;
          state_nxt = ST_LON_LD;
        end else begin
          state_nxt = ST_END;
        end
      end
      ST_LON_LD: begin
        if (sts.out_free) begin
          cmd.load_lon = 1'b1;
          state_nxt    = ST_LON_RD;
        end
      end
      ST_END: begin
        if (sts.out_free) begin
          cmd.load_end = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `NRPE_ASSERT(a_load_when_free, (cmd.load_lat || cmd.load_lon || cmd.load_end) |-> sts.out_free)
  `NRPE_ASSERT_NEXT(a_end_to_idle, cmd.load_end, state_r == ST_IDLE)
  `NRPE_ASSERT_NEXT(a_end_hit_starts, cmd.take && sts.end_hit, state_r == ST_LAT_RD)

endmodule

### src/nrpe_dp.sv
// ---------------------------------------------------------------------------
// nrpe_dp
// Datapath: header match, comma count, field stores, read-out index,
// configuration registers and the output register.
// ---------------------------------------------------------------------------
`include "nmea_rmc_position_extractor_defines.svh"

module nrpe_dp #(
  parameter int FIELD_CHARS = nrpe_pkg::FIELD_CHARS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [nrpe_pkg::BYTE_W-1:0]         in_byte,
  input  logic                                cfg_we,
  input  logic [nrpe_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [nrpe_pkg::IDX_W-1:0]          cfg_data,
  input  nrpe_pkg::nrpe_cmd_t                 cmd,
  output nrpe_pkg::nrpe_sts_t                 sts,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [nrpe_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [nrpe_pkg::KIND_W-1:0]         out_tuser,
  output logic                                out_tlast
);
  import nrpe_pkg::*;

  localparam int ADDR_W = $clog2(FIELD_CHARS);
  localparam int LEN_W  = $clog2(FIELD_CHARS + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(FIELD_CHARS);

  logic [IDX_W-1:0]  lat_idx_r, lon_idx_r;
  logic [HDR_W-1:0]  hdr_r, hdr_nxt;
  logic [IDX_W-1:0]  comma_r, comma_nxt;
  logic [LEN_W-1:0]  lat_len_r, lat_len_nxt;
  logic [LEN_W-1:0]  lon_len_r, lon_len_nxt;
  logic              drop_r, drop_nxt;
  logic [LEN_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              lat_we, lon_we;
  logic [BYTE_W-1:0] lat_rdata, lon_rdata;
  logic              end_hit;

  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_kind_r;
  logic [BYTE_W-1:0] out_char_r;
  logic              out_ovf_r;
  logic              out_last_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_idx_r <= LAT_IDX_RST;
      lon_idx_r <= LON_IDX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LAT_IDX: lat_idx_r <= cfg_data;
        CFG_LON_IDX: lon_idx_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign end_hit = (hdr_r == HDR_DONE) && (in_byte == CH_STAR) && (comma_r >= lon_idx_r);

  // sentence parsing
  always_comb begin
    hdr_nxt     = hdr_r;
    comma_nxt   = comma_r;
    lat_len_nxt = lat_len_r;
    lon_len_nxt = lon_len_r;
    drop_nxt    = drop_r;
    lat_we      = 1'b0;
    lon_we      = 1'b0;
    if (cmd.load_end) begin
      hdr_nxt     = HDR_IDLE;
      comma_nxt   = '0;
      lat_len_nxt = '0;
      lon_len_nxt = '0;
      drop_nxt    = 1'b0;
    end else if (cmd.take) begin
      if (in_byte == CH_DOLLAR) begin
        hdr_nxt     = HDR_START;
        comma_nxt   = '0;
        lat_len_nxt = '0;
        lon_len_nxt = '0;
        drop_nxt    = 1'b0;
      end else if (hdr_r != HDR_DONE) begin
        if (hdr_r != HDR_IDLE && in_byte == hdr_char(hdr_r)) begin
          hdr_nxt = hdr_r + 1'b1;
        end else begin
          hdr_nxt = HDR_IDLE;
        end
      end else if (in_byte == CH_COMMA) begin
        if (comma_r != COMMA_MAX) begin
          comma_nxt = comma_r + 1'b1;
        end
      end else if (!end_hit) begin
        if (comma_r == lat_idx_r) begin
          if (lat_len_r < LEN_MAX) begin
            lat_we      = 1'b1;
            lat_len_nxt = lat_len_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
        end else if (comma_r == lon_idx_r) begin
          if (lon_len_r < LEN_MAX) begin
            lon_we      = 1'b1;
            lon_len_nxt = lon_len_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    if (cmd.clr_idx) begin
      rd_idx_nxt = '0;
    end else if (cmd.load_lat || cmd.load_lon) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r     <= HDR_IDLE;
      comma_r   <= '0;
      lat_len_r <= '0;
      lon_len_r <= '0;
      drop_r    <= 1'b0;
      rd_idx_r  <= '0;
    end else begin
      hdr_r     <= hdr_nxt;
      comma_r   <= comma_nxt;
      lat_len_r <= lat_len_nxt;
      lon_len_r <= lon_len_nxt;
      drop_r    <= drop_nxt;
      rd_idx_r  <= rd_idx_nxt;
    end
  end

  nrpe_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FIELD_CHARS)
  ) u_lat_ram (
    .clk     (clk),
    .we      (lat_we),
    .waddr   (lat_len_r[ADDR_W-1:0]),
    .wdata   (in_byte),
    .re      (cmd.rd),
    .raddr   (rd_idx_r[ADDR_W-1:0]),
    .rdata_r (lat_rdata)
  );

  nrpe_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FIELD_CHARS)
  ) u_lon_ram (
    .clk     (clk),
    .we      (lon_we),
    .waddr   (lon_len_r[ADDR_W-1:0]),
    .wdata   (in_byte),
    .re      (cmd.rd),
    .raddr   (rd_idx_r[ADDR_W-1:0]),
    .rdata_r (lon_rdata)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_lat || cmd.load_lon || cmd.load_end) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_lat) begin
      out_kind_r <= KIND_LAT;
      out_char_r <= lat_rdata;
      out_ovf_r  <= 1'b0;
      out_last_r <= 1'b0;
    end else if (cmd.load_lon) begin
      out_kind_r <= KIND_LON;
      out_char_r <= lon_rdata;
      out_ovf_r  <= 1'b0;
      out_last_r <= 1'b0;
    end else if (cmd.load_end) begin
      out_kind_r <= KIND_END;
      out_char_r <= '0;
      out_ovf_r  <= drop_r;
      out_last_r <= 1'b1;
    end
  end

  assign sts.end_hit  = end_hit;
  assign sts.lat_more = rd_idx_r < lat_len_r;
  assign sts.lon_more = rd_idx_r < lon_len_r;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - BYTE_W - 1){1'b0}}, out_ovf_r, out_char_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  `NRPE_ASSERT(a_lat_len_bound, lat_len_r <= LEN_MAX && lon_len_r <= LEN_MAX)
  `NRPE_ASSERT(a_drop_needs_full, drop_r |-> (lat_len_r == LEN_MAX || lon_len_r == LEN_MAX))
  `NRPE_ASSERT_NEXT(a_end_clears, cmd.load_end, hdr_r == HDR_IDLE && lat_len_r == '0)

endmodule

### src/nmea_rmc_position_extractor.sv
// NMEA RMC position extractor. Bytes of the serial sentence stream enter one per cycle
// while the block is idle; "$GNRMC" is matched as consecutive bytes, '$' always restarts
// the match, and after the header the characters of the latitude and longitude fields
// (selected by comma count through the two config registers) are stored, up to
// FIELD_CHARS each, with any excess dropped and flagged. A '*' seen once the longitude
// field is reached closes the sentence: the block then sends every latitude character
// (tuser 0), every longitude character (tuser 1) and an end item (tuser 2, tlast high,
// tdata bit 8 = overflow). Read-out goes through one registered read port per store: for
// each stored character a read state fetches it and a load state moves it into the
// output register once it is free; in_tready stays low from the closing '*' until the
// end item is loaded. Config writes are always ready.
// ---------------------------------------------------------------------------
// nmea_rmc_position_extractor
// Top level: byte stream in, latitude/longitude characters out.
// ---------------------------------------------------------------------------
module nmea_rmc_position_extractor #(
  parameter int FIELD_CHARS = nrpe_pkg::FIELD_CHARS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [7:0] rx_byte
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [nrpe_pkg::BYTE_W-1:0]         in_tdata,
  // out_tdata: [7:0] char_out, [8] overflowed, [15:9] zero
  // out_tuser: [1:0] field_kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [nrpe_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [nrpe_pkg::KIND_W-1:0]         out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nrpe_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [nrpe_pkg::IDX_W-1:0]          cfg_data
);
  import nrpe_pkg::*;

  nrpe_cmd_t cmd;
  nrpe_sts_t sts;

  assign cfg_ready = 1'b1;

  nrpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nrpe_dp #(
    .FIELD_CHARS (FIELD_CHARS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
